// ----- src/bbl_pkg.sv -----
// ----------------------------------------------------------------------------
// bbl_pkg
// Shared types, constants and helpers for the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bbl_pkg;

	localparam int MAX_LINE    = 1024;
	localparam int ADDR_W      = $clog2(MAX_LINE);
	localparam int WIDTH_W     = 11;
	localparam int HEIGHT_W    = 13;
	localparam int PIX_W       = 24;
	localparam int SUM_W       = 12;
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 18;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

	// register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// one accepted pixel or drain beat, classified
	typedef struct packed {
		logic [PIX_W-1:0]  pix;
		logic [ADDR_W-1:0] addr;
		logic              out_en;
		logic [2:0]        rowm;
		logic [2:0]        colm;
		logic [3:0]        cnt;
		logic              fe;
	} cmd_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       fe;
	} res_t;

	// ceil(2^18 / (2*n)) for the neighbour counts that can occur
	function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
		logic [RECIP_W-1:0] m;
		case (n)
			4'd1:    m = 18'd131072;
			4'd2:    m = 18'd65536;
			4'd3:    m = 18'd43691;
			4'd4:    m = 18'd32768;
			4'd6:    m = 18'd21846;
			4'd9:    m = 18'd14564;
			default: m = 18'd131072;
		endcase
		return m;
	endfunction

	function automatic logic [1:0] cnt3(input logic [2:0] m);
		return 2'({1'b0, m[0]} + {1'b0, m[1]} + {1'b0, m[2]});
	endfunction

endpackage

// ----- src/box_blur_3x3_rgb_unit.sv -----
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_unit
// 3x3 box blur over an RGB raster stream with APB frame size registers.
// ----------------------------------------------------------------------------
// Sustains one pixel or drain beat per clock unless a queue is full: each
// beat does one read and one write of the line store, whose read is registered
// on the way to the result queue. Results appear once the pixel below
// and to the right has arrived; after the frame's last pixel, one beat per
// outstanding result drains the rest (push with flush, or any push). Flush
// beats during a frame are taken and discarded. Writing a register restarts
// the frame position; write only while the block is idle.
module box_blur_3x3_rgb_unit import bbl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic        flush,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        frame_end
);

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic                cfg_wr;
	logic                q_wr, q_rd, q_empty;
	cmd_t                q_cmd, q_head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= pwdata[HEIGHT_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {19'd0, height_q};
			default:    prdata = '0;
		endcase
	end

	bbl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_width  (width_q),
		.cfg_height (height_q),
		.cfg_clear  (cfg_wr),
		.push       (push),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.flush      (flush),
		.q_full     (full),
		.q_wr       (q_wr),
		.q_cmd      (q_cmd)
	);

	bbl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_cmd),
		.full    (full),
		.rd_en   (q_rd),
		.q_empty (q_empty),
		.rd_data (q_head)
	);

	bbl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_rd      (q_rd),
		.empty     (empty),
		.pop       (pop),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.frame_end (frame_end)
	);

endmodule

// ----- src/bbl_queue.sv -----
// ----------------------------------------------------------------------------
// bbl_queue
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module bbl_queue import bbl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output logic q_empty,
	output cmd_t rd_data
);

	localparam int DEPTH = 4;

	cmd_t       mem_q [DEPTH];
	logic [1:0] wptr_q, rptr_q;
	logic [2:0] cnt_q;

	assign full    = cnt_q == 3'(DEPTH);
	assign q_empty = cnt_q == 3'd0;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en)
				wptr_q <= wptr_q + 2'd1;
			if (rd_en)
				rptr_q <= rptr_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr_en} - {2'd0, rd_en};
		end
	end

endmodule

// ----- src/bbl_front.sv -----
// ----------------------------------------------------------------------------
// bbl_front
// Input side: tracks frame position, drops stray flushes and works out the
// neighbourhood mask and count for the output each beat releases.
// ----------------------------------------------------------------------------
module bbl_front import bbl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [WIDTH_W-1:0]  cfg_width,
	input  logic [HEIGHT_W-1:0] cfg_height,
	input  logic                cfg_clear,
	input  logic                push,
	input  logic [7:0]          red_in,
	input  logic [7:0]          green_in,
	input  logic [7:0]          blue_in,
	input  logic                flush,
	input  logic                q_full,
	output logic                q_wr,
	output cmd_t                q_cmd
);

	logic [ADDR_W-1:0]   col_q;
	// one bit wider than the height: drain rows run up to height + 1
	logic [HEIGHT_W:0]   row_q;
	logic [WIDTH_W-1:0]  w_eff, j;
	logic [HEIGHT_W-1:0] h_eff, i;
	logic                draining, accept, col_last, out_en, fe;
	logic [2:0]          rowm, colm;
	logic [3:0]          prod;

	always_comb begin
		if (cfg_width == '0)
			w_eff = 11'd1;
		else if (cfg_width > WIDTH_W'(MAX_LINE))
			w_eff = WIDTH_W'(MAX_LINE);
		else
			w_eff = cfg_width;
		h_eff = (cfg_height == '0) ? 13'd1 : cfg_height;
	end

	assign draining = row_q >= {1'b0, h_eff};
	assign accept   = push && !q_full;
	assign q_wr     = accept && (draining || !flush);
	assign col_last = ({1'b0, col_q} + 11'd1) >= w_eff;
	assign out_en   = (col_q != '0) ? (row_q >= 14'd1) : (row_q >= 14'd2);

	always_comb begin
		if (col_q == '0) begin
			i = HEIGHT_W'(row_q - 14'd2);
			j = w_eff - 11'd1;
		end else begin
			i = HEIGHT_W'(row_q - 14'd1);
			j = {1'b0, col_q} - 11'd1;
		end
		rowm[0] = (i >= 13'd1) && (i <= h_eff);
		rowm[1] = i < h_eff;
		rowm[2] = ({1'b0, i} + 14'd1) < {1'b0, h_eff};
		colm[0] = (j >= 11'd1) && (j <= w_eff);
		colm[1] = j < w_eff;
		colm[2] = ({1'b0, j} + 12'd1) < {1'b0, w_eff};
		fe      = out_en && (i == h_eff - 13'd1) && (j == w_eff - 11'd1);
		prod    = 4'({2'd0, cnt3(rowm)} * {2'd0, cnt3(colm)});
	end

	always_comb begin
		q_cmd.pix    = draining ? '0 : {red_in, green_in, blue_in};
		q_cmd.addr   = col_q;
		q_cmd.out_en = out_en;
		q_cmd.rowm   = rowm;
		q_cmd.colm   = colm;
		q_cmd.cnt    = (prod == 4'd0) ? 4'd1 : prod;
		q_cmd.fe     = fe;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_clear || (q_wr && fe)) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_wr) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_q + 14'd1;
			end else begin
				col_q <= col_q + 10'd1;
			end
		end
	end

endmodule

// ----- src/bbl_back.sv -----
// ----------------------------------------------------------------------------
// bbl_back
// Line stores, 3x3 window, masked sums, rounding divide and result queue.
// ----------------------------------------------------------------------------
module bbl_back import bbl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_head,
	output logic       q_rd,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic       frame_end
);

	localparam int ODEPTH = 8;

	// both line stores side by side: {upper, middle}
	logic [2*PIX_W-1:0] lstore [MAX_LINE];
	logic [2*PIX_W-1:0] rd_s1;
	logic [2*PIX_W-1:0] fwd_data_q;
	logic               fwd_s1;
	cmd_t               cmd_s1, cmd_s2, cmd_s3;
	logic               v_s1, v_s2, v_s3;
	logic [PIX_W-1:0]   col_up, col_mid;
	logic [PIX_W-1:0]   win_q [3][3];
	logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
	logic [SUM_W-1:0]   sr_s3, sg_s3, sb_s3;
	logic [1:0]         inflight;
	logic [3:0]         ocnt_q;
	logic [2:0]         owp_q, orp_q;
	res_t               ofifo_q [ODEPTH];
	res_t               res;
	logic               opush, opop;
	logic [RECIP_W-1:0] m;
	logic [12:0]        xr, xg, xb;
	logic [30:0]        pr, pg, pb;

	assign inflight = 2'({1'b0, v_s1} + {1'b0, v_s2} + {1'b0, v_s3});
	assign q_rd     = !q_empty && (({1'b0, ocnt_q} + {3'd0, inflight}) < 5'(ODEPTH));

	// a write in the same cycle as the read of the same column is forwarded
	assign col_up  = fwd_s1 ? fwd_data_q[2*PIX_W-1:PIX_W] : rd_s1[2*PIX_W-1:PIX_W];
	assign col_mid = fwd_s1 ? fwd_data_q[PIX_W-1:0]       : rd_s1[PIX_W-1:0];

	always_ff @(posedge clk) begin
		if (q_rd)
			rd_s1 <= lstore[q_head.addr];
		if (v_s1)
			lstore[cmd_s1.addr] <= {col_mid, cmd_s1.pix};
	end

	always_ff @(posedge clk) begin
		if (q_rd)
			cmd_s1 <= q_head;
		fwd_data_q <= {col_mid, cmd_s1.pix};
		cmd_s2 <= cmd_s1;
		cmd_s3 <= cmd_s2;
		sr_s3  <= sum_r;
		sg_s3  <= sum_g;
		sb_s3  <= sum_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= q_rd;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			fwd_s1 <= q_rd && v_s1 && (q_head.addr == cmd_s1.addr);
		end
	end

	// window: row 0 is the oldest line, column 2 the newest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					win_q[r][c] <= '0;
		end else if (v_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= col_up;
			win_q[1][2] <= col_mid;
			win_q[2][2] <= cmd_s1.pix;
		end
	end

	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				if (cmd_s2.rowm[r] && cmd_s2.colm[c]) begin
					sum_r = sum_r + {4'd0, win_q[r][c][23:16]};
					sum_g = sum_g + {4'd0, win_q[r][c][15:8]};
					sum_b = sum_b + {4'd0, win_q[r][c][7:0]};
				end
	end

	// floor((2*sum + n) / (2*n)) by reciprocal multiply
	always_comb begin
		m   = recip(cmd_s3.cnt);
		xr  = {sr_s3, 1'b0} + {9'd0, cmd_s3.cnt};
		xg  = {sg_s3, 1'b0} + {9'd0, cmd_s3.cnt};
		xb  = {sb_s3, 1'b0} + {9'd0, cmd_s3.cnt};
		pr  = {18'd0, xr} * {13'd0, m};
		pg  = {18'd0, xg} * {13'd0, m};
		pb  = {18'd0, xb} * {13'd0, m};
		res.red   = pr[RECIP_SHIFT+7:RECIP_SHIFT];
		res.green = pg[RECIP_SHIFT+7:RECIP_SHIFT];
		res.blue  = pb[RECIP_SHIFT+7:RECIP_SHIFT];
		res.fe    = cmd_s3.fe;
	end

	assign opush = v_s3 && cmd_s3.out_en;
	assign opop  = pop && !empty;
	assign empty = ocnt_q == 4'd0;

	always_ff @(posedge clk) begin
		if (opush)
			ofifo_q[owp_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (opush)
				owp_q <= owp_q + 3'd1;
			if (opop)
				orp_q <= orp_q + 3'd1;
			ocnt_q <= ocnt_q + {3'd0, opush} - {3'd0, opop};
		end
	end

	assign red_out   = ofifo_q[orp_q].red;
	assign green_out = ofifo_q[orp_q].green;
	assign blue_out  = ofifo_q[orp_q].blue;
	assign frame_end = ofifo_q[orp_q].fe;

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, ocnt_q} + {3'd0, inflight}) <= 5'(ODEPTH))
		else $error("result queue overbooked");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		opush |-> (ocnt_q < 4'(ODEPTH)) || opop)
		else $error("result written into full queue");

	a_fwd_back2back: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> v_s1 && $past(v_s1))
		else $error("forward without a preceding beat");

	a_pop_credit: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |=> v_s1)
		else $error("popped beat lost");

endmodule

// ----- tb/box_blur_3x3_rgb_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_checker
// Watches the pixel, result and register channels of the blur unit, keeps
// its own model of the line stores and window, and compares every result beat.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_checker import bbl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic        flush,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  red_out,
	input  logic [7:0]  green_out,
	input  logic [7:0]  blue_out,
	input  logic        frame_end,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       fe;
	} blur_px_t;

	logic [PIX_W-1:0]    upper_line [MAX_LINE];
	logic [PIX_W-1:0]    middle_line [MAX_LINE];
	logic [PIX_W-1:0]    win [9];
	int unsigned         col_in, row_in;
	logic [WIDTH_W-1:0]  cfg_width;
	logic [HEIGHT_W-1:0] cfg_height;
	blur_px_t            blurred_q[$];

	assign pending = blurred_q.size();

	task automatic report(input string what, input blur_px_t got, input blur_px_t want);
		$display("mismatch %s: got %h %h %h fe=%b, want %h %h %h fe=%b", what,
			got.red, got.green, got.blue, got.fe, want.red, want.green, want.blue, want.fe);
		fail_count++;
	endtask

	// advance the model by one accepted beat
	task automatic blur_step(input logic [PIX_W-1:0] px_in, input logic fl);
		int unsigned w, h, r, c, idx, i, j, n;
		int unsigned s [3];
		logic [PIX_W-1:0] cl [3];
		logic [PIX_W-1:0] p, px;
		blur_px_t res;
		w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_LINE) ? MAX_LINE : cfg_width);
		h = (cfg_height == 0) ? 1 : cfg_height;
		r = row_in;
		c = col_in;
		if (r < h && fl) return;
		px = (r >= h) ? '0 : px_in;
		idx = (c < MAX_LINE) ? c : 0;
		cl[0] = upper_line[idx];
		cl[1] = middle_line[idx];
		cl[2] = px;
		upper_line[idx] = cl[1];
		middle_line[idx] = px;
		for (int k = 0; k < 3; k++) begin
			win[k*3] = win[k*3+1];
			win[k*3+1] = win[k*3+2];
			win[k*3+2] = cl[k];
		end
		if (c + 1 >= w) begin
			col_in = 0;
			row_in = r + 1;
		end else
			col_in = c + 1;
		if (c == 0) begin
			if (r < 2) return;
			i = r - 2;
			j = w - 1;
		end else begin
			if (r < 1) return;
			i = r - 1;
			j = c - 1;
		end
		s = '{0, 0, 0};
		n = 0;
		for (int kr = 0; kr < 3; kr++) begin
			if (i + kr < 1 || i + kr > h) continue;
			for (int kc = 0; kc < 3; kc++) begin
				if (j + kc < 1 || j + kc > w) continue;
				p = win[kr*3+kc];
				s[0] += p[23:16];
				s[1] += p[15:8];
				s[2] += p[7:0];
				n++;
			end
		end
		if (n == 0) n = 1;
		res.red   = 8'((2*s[0] + n) / (2*n));
		res.green = 8'((2*s[1] + n) / (2*n));
		res.blue  = 8'((2*s[2] + n) / (2*n));
		res.fe    = (i == h - 1 && j == w - 1);
		if (res.fe) begin
			col_in = 0;
			row_in = 0;
		end
		blurred_q.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		blur_px_t got, want;
		if (!arst_n) begin
			fail_count = 0;
			col_in = 0;
			row_in = 0;
			cfg_width = WIDTH_RESET;
			cfg_height = HEIGHT_RESET;
			foreach (win[k]) win[k] = '0;
			blurred_q.delete();
		end else begin
			if (!empty && pop) begin
				got = '{red_out, green_out, blue_out, frame_end};
				if (blurred_q.size() == 0)
					report("unexpected beat", got, got);
				else begin
					want = blurred_q.pop_front();
					if (got !== want) report("pixel", got, want);
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_WIDTH) cfg_width = pwdata[WIDTH_W-1:0];
				else cfg_height = pwdata[HEIGHT_W-1:0];
				col_in = 0;
				row_in = 0;
			end
			if (push && !full)
				blur_step({red_in, green_in, blue_in}, flush);
		end
	end

endmodule

// ----- tb/box_blur_3x3_rgb_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_unit_tb
// Streams frames of several sizes, with flush beats and random gaps, into the
// blur unit; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_unit_tb;
	import bbl_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        push, full, flush, empty, pop, frame_end;
	logic [7:0]  red_in, green_in, blue_in, red_out, green_out, blue_out;
	int          fail_count, pending, idle_cycles;
	int          gap_pct;
	int          sent_beats;

	box_blur_3x3_rgb_unit u_top (.*);

	box_blur_3x3_rgb_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles with no beat on the pixel, result or register channel
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (psel && penable)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side stalls
	always @(posedge clk) pop <= ($urandom_range(99) >= gap_pct);

	task automatic reg_write(input logic idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// push stays high after the beat; the next beat or a gap takes it over
	task automatic send_beat(input logic [23:0] px, input logic fl);
		while ($urandom_range(99) < gap_pct) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		{red_in, green_in, blue_in} <= px;
		flush <= fl;
		do @(posedge clk); while (full);
		sent_beats++;
	endtask

	task automatic wait_drained();
		push <= 0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_frame(input int w, input int h);
		wait_drained();
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
	endtask

	// pixels of a frame, with optional stray flushes, then n_drain drain beats
	task automatic run_part(input int w, input int h, input int mode, input int n_drain);
		logic [23:0] px;
		for (int k = 0; k < w * h; k++) begin
			case (mode)
				0: px = 24'($urandom);
				1: px = (k % 2) ? 24'hFFFFFF : 24'h000000;
				default: px = {$urandom_range(1) ? 8'hFF : 8'h00, 8'($urandom),
					$urandom_range(1) ? 8'h01 : 8'hFE};
			endcase
			if ($urandom_range(19) == 0) send_beat(24'($urandom), 1'b1);
			send_beat(px, 1'b0);
		end
		for (int k = 0; k < n_drain; k++) send_beat(24'($urandom), 1'($urandom));
	endtask

	// drain: a virtual row, the next row's first column and one spare beat
	task automatic run_frame(input int w, input int h, input int mode);
		run_part(w, h, mode, w + 2);
	endtask

	initial begin
		int w, h;
		push = 0; flush = 0; red_in = 0; green_in = 0; blue_in = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		gap_pct = 22; sent_beats = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: tiny frames, extremes and degenerate sizes
		set_frame(1, 1);   run_frame(1, 1, 1);
		set_frame(3, 3);   run_frame(3, 3, 1);
		set_frame(0, 0);   run_frame(1, 1, 2);
		set_frame(4, 1);   run_frame(4, 1, 2);
		set_frame(1, 4);   run_frame(1, 4, 0);
		set_frame(2, 2);   run_frame(2, 2, 2);
		// widest line, abandoned after a few drain outputs
		set_frame(2047, 1); run_part(1024, 1, 2, 6);
		set_frame(1, 4096); run_frame(1, 20, 0);
		set_frame(1, 8191); run_frame(1, 3, 2);
		// random frames, one stretch with no gaps
		while (sent_beats < 1950) begin
			gap_pct = (sent_beats > 1200 && sent_beats < 1600) ? 0 : 22;
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 8);
			set_frame(w, h);
			run_frame(w, h, $urandom_range(2));
		end
		gap_pct = 22;
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
